// File: rtl/zero_order_hold_resampler_defines.svh
// assertion macros included by zohr_ctrl
`ifndef ZERO_ORDER_HOLD_RESAMPLER_DEFINES_SVH
`define ZERO_ORDER_HOLD_RESAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define ZOHR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition that must never be true outside reset
`define ZOHR_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ZOHR_ASSERT(lbl, prop, msg)
`define ZOHR_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/zohr_pkg.sv
`default_nettype none
package zohr_pkg;

	// widths
	localparam int RATE_W   = 18;
	localparam int ACC_W    = 19;
	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// run limits
	localparam int MAX_RUN = 45;
	localparam int CNT_W   = 6;
	localparam logic [RATE_W-1:0] MIN_RATE   = 18'd1000;
	localparam logic [RATE_W-1:0] RESET_RATE = 18'd44100;

	// register addresses
	localparam logic [ADDR_W-1:0] ADDR_NATIVE_RATE  = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_STEREO_IN    = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_WIDE_SAMPLES = 4'h8;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// emit control from sequencer to output register
	typedef struct packed {
		logic emit;
		logic last;
	} ctl_t;

endpackage
`default_nettype wire

// File: rtl/zohr_fmt.sv
`default_nettype none
module zohr_fmt (
	input  wire logic [zohr_pkg::SAMPLE_W-1:0] first_sample,
	input  wire logic [zohr_pkg::SAMPLE_W-1:0] second_sample,
	input  wire logic                          stereo_in,
	input  wire logic                          wide_samples,
	output logic signed [zohr_pkg::SAMPLE_W-1:0] left,
	output logic signed [zohr_pkg::SAMPLE_W-1:0] right
);
	import zohr_pkg::*;

	logic [SAMPLE_W-1:0] first_byte_word;
	logic [SAMPLE_W-1:0] second_byte_word;
	logic [SAMPLE_W-1:0] first_word;
	logic [SAMPLE_W-1:0] second_word;

	// unsigned byte to signed word: (b - 128) * 256
	assign first_byte_word  = {~first_sample[7], first_sample[6:0], 8'h00};
	assign second_byte_word = {~second_sample[7], second_sample[6:0], 8'h00};

	// sample size select
	assign first_word  = wide_samples ? first_sample : first_byte_word;
	assign second_word = wide_samples ? second_sample : second_byte_word;

	// mono duplicates the first word
	assign left  = first_word;
	assign right = stereo_in ? second_word : first_word;

endmodule
`default_nettype wire

// File: rtl/zohr_step.sv
`default_nettype none
module zohr_step (
	input  wire logic [zohr_pkg::ACC_W-1:0]  acc,
	input  wire logic [zohr_pkg::RATE_W-1:0] rate,
	output logic [zohr_pkg::ACC_W-1:0]       diff,
	output logic                             more,
	output logic                             again
);
	import zohr_pkg::*;

	logic [ACC_W-1:0] rate_ext;

	assign rate_ext = {1'b0, rate};

	// one subtract step and the two loop tests around it
	assign more  = acc > rate_ext;
	assign diff  = acc - rate_ext;
	assign again = diff > rate_ext;

endmodule
`default_nettype wire

// File: rtl/zohr_ctrl.sv
`default_nettype none
`include "zero_order_hold_resampler_defines.svh"
module zohr_ctrl #(
	parameter int unsigned OUTPUT_RATE = 44100
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_fire,
	input  wire logic [zohr_pkg::RATE_W-1:0]   native_rate,
	input  wire logic                          slot_free,
	output logic                               busy,
	output zohr_pkg::ctl_t                     ctl
);
	import zohr_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [ACC_W-1:0]  acc_q;
	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] phase_q;
	logic [RATE_W-1:0] eff_rate;
	logic [ACC_W-1:0]  diff;
	logic              more;
	logic              again;
	logic              done;

	// shared subtract and compare unit
	zohr_step u_step (
		.acc   (acc_q),
		.rate  (rate_q),
		.diff  (diff),
		.more  (more),
		.again (again)
	);

	// low rates are raised to the floor
	assign eff_rate = (native_rate < MIN_RATE) ? MIN_RATE : native_rate;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b1;
		ctl.emit = 1'b0;
		ctl.last = 1'b0;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_RUN: begin
				ctl.emit = more && slot_free;
				ctl.last = ctl.emit && (!again || cnt_q == CNT_W'(MAX_RUN - 1));
				done     = !more || ctl.last;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// accumulator, rate and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			rate_q  <= RESET_RATE;
			cnt_q   <= '0;
			phase_q <= '0;
		end else begin
			if (in_fire) begin
				acc_q  <= {1'b0, phase_q} + ACC_W'(OUTPUT_RATE);
				rate_q <= eff_rate;
				cnt_q  <= '0;
			end else if (ctl.emit) begin
				acc_q <= diff;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// leftover phase, clamped when the run hits its cap
			if (done) begin
				if (more) begin
					phase_q <= again ? rate_q : diff[RATE_W-1:0];
				end else begin
					phase_q <= acc_q[RATE_W-1:0];
				end
			end
		end
	end

	`ZOHR_NEVER(a_cnt_cap, cnt_q > CNT_W'(MAX_RUN), "run count past cap")
	`ZOHR_ASSERT(a_phase_bound, done |=> phase_q <= rate_q, "phase above rate after run")
	`ZOHR_ASSERT(a_run_cont, (ctl.emit && !ctl.last) |=> state_q == ST_RUN, "run ended early")

endmodule
`default_nettype wire

// File: rtl/zero_order_hold_resampler.sv
// on acceptance the sequencer state and accumulator are registered, then each word
//   of the run is registered in the output word register; an input yields n <= 45 words,
//   one word per cycle while the output is not stalled, from a single shared subtract/compare step unit
// output stalls hold the run; the next input is taken once the run is done
// reset (arst_n low): phase and held frame cleared, native_rate 44100,
//   stereo and 16-bit input selected, no word pending
`default_nettype none
module zero_order_hold_resampler #(
	parameter int unsigned OUTPUT_RATE = 44100
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [zohr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [zohr_pkg::DATA_W-1:0]   pwdata,
	output logic [zohr_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [zohr_pkg::SAMPLE_W-1:0] first_sample,
	input  wire logic [zohr_pkg::SAMPLE_W-1:0] second_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [zohr_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [zohr_pkg::SAMPLE_W-1:0] right_out,
	output logic                               last_of_run
);
	import zohr_pkg::*;

	logic [RATE_W-1:0]          native_rate_q;
	logic                       stereo_in_q;
	logic                       wide_samples_q;
	logic                       wr_en;
	logic                       in_fire;
	logic                       busy;
	logic                       slot_free;
	ctl_t                       ctl;
	logic signed [SAMPLE_W-1:0] fmt_left;
	logic signed [SAMPLE_W-1:0] fmt_right;
	logic signed [SAMPLE_W-1:0] held_left_q;
	logic signed [SAMPLE_W-1:0] held_right_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       last_q;

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_rate_q  <= RESET_RATE;
			stereo_in_q    <= 1'b1;
			wide_samples_q <= 1'b1;
		end else if (wr_en) begin
			case (paddr)
				ADDR_NATIVE_RATE:  native_rate_q  <= pwdata[RATE_W-1:0];
				ADDR_STEREO_IN:    stereo_in_q    <= pwdata[0];
				ADDR_WIDE_SAMPLES: wide_samples_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_NATIVE_RATE:  prdata = {{(DATA_W-RATE_W){1'b0}}, native_rate_q};
			ADDR_STEREO_IN:    prdata = {{(DATA_W-1){1'b0}}, stereo_in_q};
			ADDR_WIDE_SAMPLES: prdata = {{(DATA_W-1){1'b0}}, wide_samples_q};
			default:           prdata = '0;
		endcase
	end

	// input handshake
	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;

	// sample format conversion
	zohr_fmt u_fmt (
		.first_sample  (first_sample),
		.second_sample (second_sample),
		.stereo_in     (stereo_in_q),
		.wide_samples  (wide_samples_q),
		.left          (fmt_left),
		.right         (fmt_right)
	);

	// held frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= '0;
			held_right_q <= '0;
		end else if (in_fire) begin
			held_left_q  <= fmt_left;
			held_right_q <= fmt_right;
		end
	end

	// phase sequencer
	zohr_ctrl #(
		.OUTPUT_RATE (OUTPUT_RATE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.native_rate (native_rate_q),
		.slot_free   (slot_free),
		.busy        (busy),
		.ctl         (ctl)
	);

	// output word register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			left_q  <= held_left_q;
			right_q <= held_right_q;
			last_q  <= ctl.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_out    = left_q;
	assign right_out   = right_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire
